// ===== design/clint_pkg.sv =====
package clint_pkg;

  // item operation codes
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // default hart count and the number of harts visible on the line outputs
  localparam int HARTS_DEF = 4;
  localparam int LINE_BITS = 4;

  // field widths
  localparam int OP_W   = 2;
  localparam int ADDR_W = 16;
  localparam int DATA_W = 32;
  localparam int SIZE_W = 4;
  localparam int TIME_W = 64;

  // only word-sized accesses are legal
  localparam logic [SIZE_W-1:0] ACCESS_WORD = 4'd4;

  // address map
  localparam logic [ADDR_W-1:0] SOFT_BASE = 16'h0000;
  localparam logic [ADDR_W-1:0] CMP_BASE  = 16'h4000;
  localparam logic [ADDR_W-1:0] TIME_LO   = 16'hBFF8;
  localparam logic [ADDR_W-1:0] TIME_HI   = 16'hBFFC;

  // commands from the controller to the datapath
  typedef struct packed {
    logic item_load;
    logic mem_read;
    logic execute;
    logic result_load;
  } cmd_t;

endpackage

// ===== design/clint_ctrl.sv =====
module clint_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output clint_pkg::cmd_t   cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // sequencing of one request: accept, store read, update, result
  always_comb begin
    state_nxt       = state_r;
    cmd.item_load   = 1'b0;
    cmd.mem_read    = 1'b0;
    cmd.execute     = 1'b0;
    cmd.result_load = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.item_load = 1'b1;
          state_nxt     = S_READ;
        end
      end
      S_READ: begin
        cmd.mem_read = 1'b1;
        state_nxt    = S_EXEC;
      end
      S_EXEC: begin
        cmd.execute = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.result_load = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result valid holds until the downstream side takes it
  always_comb begin
    out_valid_nxt = cmd.result_load | (out_valid_r & out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // accepted request walks through read and update in order
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> cmd.mem_read ##1 cmd.execute)
    else $error("request did not go through read and update");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !cmd.result_load)
    else $error("pending result overwritten");

  // loading a result raises valid
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.result_load |=> out_valid_r)
    else $error("result loaded without valid");

endmodule

// ===== design/clint_dp.sv =====
module clint_dp #(
  parameter int HARTS = clint_pkg::HARTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  clint_pkg::cmd_t               cmd,
  input  logic [clint_pkg::OP_W-1:0]    in_operation,
  input  logic [clint_pkg::ADDR_W-1:0]  in_address,
  input  logic [clint_pkg::DATA_W-1:0]  in_write_data,
  input  logic [clint_pkg::SIZE_W-1:0]  in_access_bytes,
  output logic [clint_pkg::DATA_W-1:0]  out_read_data,
  output logic                          out_access_error,
  output logic [clint_pkg::LINE_BITS-1:0] out_soft_irq_lines,
  output logic [clint_pkg::LINE_BITS-1:0] out_timer_irq_lines
);

  localparam int HW    = (HARTS > 1) ? $clog2(HARTS) : 1;
  localparam int LINES = (HARTS < clint_pkg::LINE_BITS) ? HARTS : clint_pkg::LINE_BITS;
  localparam int DW    = clint_pkg::DATA_W;
  localparam int TW    = clint_pkg::TIME_W;
  localparam logic [clint_pkg::ADDR_W-1:0] SOFT_END =
    clint_pkg::ADDR_W'(clint_pkg::SOFT_BASE + HARTS * 4);
  localparam logic [clint_pkg::ADDR_W-1:0] CMP_END =
    clint_pkg::ADDR_W'(clint_pkg::CMP_BASE + HARTS * 8);

  // latched request
  logic [clint_pkg::OP_W-1:0]   op_r;
  logic [clint_pkg::ADDR_W-1:0] addr_r;
  logic [DW-1:0]                wdata_r;
  logic [clint_pkg::SIZE_W-1:0] size_r;

  // architectural state
  logic [TW-1:0]    time_r, time_nxt;
  logic [HARTS-1:0] soft_r;
  logic [HARTS-1:0] cmp_vld_r;
  logic [TW-1:0]    cmp_mem [HARTS];
  logic [TW-1:0]    cmp_rd_r;
  logic [TW-1:0]    shadow_r [LINES];

  // result registers
  logic [DW-1:0] rd_r, rd_nxt;
  logic          err_r, err_nxt;
  logic [DW-1:0] out_rd_r;
  logic          out_err_r;
  logic [clint_pkg::LINE_BITS-1:0] out_soft_r, out_tmr_r;
  logic [clint_pkg::LINE_BITS-1:0] soft_lines, tmr_lines;

  // decode
  logic          is_bus, is_wr, is_tick;
  logic          soft_hit, cmp_hit, tlo_hit, thi_hit, mapped, form_ok, acc_ok;
  logic [HW-1:0] soft_idx, cmp_idx;
  logic          high;
  logic [TW-1:0] cmp_new;
  logic          wr_cmp, wr_soft;

  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      op_r    <= in_operation;
      addr_r  <= in_address;
      wdata_r <= in_write_data;
      size_r  <= in_access_bytes;
    end
  end

  // address and operation decode
  always_comb begin
    is_bus   = (op_r == clint_pkg::OP_READ) || (op_r == clint_pkg::OP_WRITE);
    is_wr    = (op_r == clint_pkg::OP_WRITE);
    is_tick  = (op_r == clint_pkg::OP_TICK);
    soft_hit = (addr_r < SOFT_END);
    cmp_hit  = (addr_r >= clint_pkg::CMP_BASE) && (addr_r < CMP_END);
    tlo_hit  = (addr_r == clint_pkg::TIME_LO);
    thi_hit  = (addr_r == clint_pkg::TIME_HI);
    mapped   = soft_hit | cmp_hit | tlo_hit | thi_hit;
    form_ok  = (addr_r[1:0] == 2'b00) && (size_r == clint_pkg::ACCESS_WORD);
    acc_ok   = is_bus & form_ok & mapped;
    err_nxt  = is_bus & ~(form_ok & mapped);
    soft_idx = addr_r[HW+1:2];
    cmp_idx  = addr_r[HW+2:3];
    high     = addr_r[2];
    wr_cmp   = acc_ok & is_wr & cmp_hit;
    wr_soft  = acc_ok & is_wr & soft_hit;
  end

  // merge the written half into the current compare value
  always_comb begin
    cmp_new = high ? {wdata_r, cmp_rd_r[DW-1:0]} : {cmp_rd_r[TW-1:DW], wdata_r};
  end

  // read data
  always_comb begin
    rd_nxt = '0;
    if (acc_ok && !is_wr) begin
      if (soft_hit) begin
        rd_nxt = {{(DW-1){1'b0}}, soft_r[soft_idx]};
      end else if (cmp_hit) begin
        rd_nxt = high ? cmp_rd_r[TW-1:DW] : cmp_rd_r[DW-1:0];
      end else if (thi_hit) begin
        rd_nxt = time_r[TW-1:DW];
      end else begin
        rd_nxt = time_r[DW-1:0];
      end
    end
  end

  // time counter update
  always_comb begin
    time_nxt = time_r;
    if (is_tick) begin
      time_nxt = time_r + TW'(1);
    end else if (acc_ok && is_wr && tlo_hit) begin
      time_nxt = {time_r[TW-1:DW], wdata_r};
    end else if (acc_ok && is_wr && thi_hit) begin
      time_nxt = {wdata_r, time_r[DW-1:0]};
    end
  end

  // compare store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.execute && wr_cmp) begin
      cmp_mem[cmp_idx] <= cmp_new;
    end
    if (cmd.mem_read) begin
      cmp_rd_r <= cmp_vld_r[cmp_idx] ? cmp_mem[cmp_idx] : '1;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r    <= '0;
      soft_r    <= '0;
      cmp_vld_r <= '0;
      for (int i = 0; i < LINES; i++) begin
        shadow_r[i] <= '1;
      end
    end else if (cmd.execute) begin
      time_r <= time_nxt;
      if (wr_soft) begin
        soft_r[soft_idx] <= wdata_r[0];
      end
      if (wr_cmp) begin
        cmp_vld_r[cmp_idx] <= 1'b1;
      end
      for (int i = 0; i < LINES; i++) begin
        if (wr_cmp && (cmp_idx == HW'(i))) begin
          shadow_r[i] <= cmp_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      rd_r  <= rd_nxt;
      err_r <= err_nxt;
    end
  end

  // interrupt levels of the visible harts
  always_comb begin
    soft_lines = '0;
    tmr_lines  = '0;
    for (int i = 0; i < LINES; i++) begin
      soft_lines[i] = soft_r[i];
      tmr_lines[i]  = (time_r >= shadow_r[i]);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      out_rd_r   <= rd_r;
      out_err_r  <= err_r;
      out_soft_r <= soft_lines;
      out_tmr_r  <= tmr_lines;
    end
  end

  assign out_read_data       = out_rd_r;
  assign out_access_error    = out_err_r;
  assign out_soft_irq_lines  = out_soft_r;
  assign out_timer_irq_lines = out_tmr_r;

  // a tick advances time by exactly one
  a_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.execute && is_tick) |=> (time_r == $past(time_r) + TW'(1)))
    else $error("tick did not advance time by one");

  // a faulting access leaves the time counter, soft bits and compare valid flags alone
  a_err_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.execute && err_nxt) |=> ($stable(time_r) && $stable(soft_r) && $stable(cmp_vld_r)))
    else $error("faulting access changed state");

  // a faulting access reads zero
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.execute && err_nxt) |-> (rd_nxt == '0))
    else $error("faulting access returned data");

endmodule

// ===== design/core_local_timer_interrupt_unit_top.sv =====
// Core-local interruptor with one software-interrupt bit and one 64-bit timer
// compare per hart and a free 64-bit time counter. Each request is a 32-bit bus
// read, a 32-bit bus write, or a time tick, and yields one result with the read
// data, an error flag, and the soft and timer interrupt levels of harts 0 to 3
// after the update. A request passes through four steps (accept, compare-store
// read, update, result load), and no new request is accepted until its result
// is loaded; the result load waits while a pending result is held by out_stall.
// The compare-store read step is needed by the registered read port of the
// per-hart compare store. Misaligned, non-word and unmapped accesses change
// nothing, read zero and set the error flag. Compare values reset to all ones;
// the time counter and soft bits to zero.
module core_local_timer_interrupt_unit_top #(
  parameter int HARTS = clint_pkg::HARTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [clint_pkg::OP_W-1:0]      in_operation,
  input  logic [clint_pkg::ADDR_W-1:0]    in_address,
  input  logic [clint_pkg::DATA_W-1:0]    in_write_data,
  input  logic [clint_pkg::SIZE_W-1:0]    in_access_bytes,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [clint_pkg::DATA_W-1:0]    out_read_data,
  output logic                            out_access_error,
  output logic [clint_pkg::LINE_BITS-1:0] out_soft_irq_lines,
  output logic [clint_pkg::LINE_BITS-1:0] out_timer_irq_lines
);

  clint_pkg::cmd_t cmd;

  // sequencer
  clint_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // registers, compare store and result path
  clint_dp #(
    .HARTS (HARTS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .in_operation        (in_operation),
    .in_address          (in_address),
    .in_write_data       (in_write_data),
    .in_access_bytes     (in_access_bytes),
    .out_read_data       (out_read_data),
    .out_access_error    (out_access_error),
    .out_soft_irq_lines  (out_soft_irq_lines),
    .out_timer_irq_lines (out_timer_irq_lines)
  );

endmodule
